// ----- sv/pair_sorter_with_label_tiebreak_macros.svh -----
// assertion macros used by the pair sorter back end
`ifndef PAIR_SORTER_WITH_LABEL_TIEBREAK_MACROS_SVH
`define PAIR_SORTER_WITH_LABEL_TIEBREAK_MACROS_SVH

// condition holds at every clock edge outside reset
`define PST_ASSERT_ALWAYS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pair sorter check failed");

// consequent holds in the cycle after the antecedent
`define PST_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pair sorter check failed");

`endif

// ----- sv/pst_pkg.sv -----
// types, constants and compare function of the pair sorter
`default_nettype none
package pst_pkg;
	localparam int MAX_PAIRS    = 64;
	localparam int LABEL_BITS   = 8;
	localparam int DIST_W       = 32;
	localparam int LABEL_W      = 8;
	localparam int RANK_W       = 6;
	localparam int CNT_W        = $clog2(MAX_PAIRS + 1);
	localparam int KEPT_LABEL_W = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [DIST_W-1:0]       distance;
		logic [KEPT_LABEL_W-1:0] label;
	} pair_t;

	typedef struct packed {
		pair_t pair;
		logic  keep;
		logic  fin;
		logic  ovf;
	} q_entry_t;

	typedef enum logic {
		BK_LOAD,
		BK_DRAIN
	} back_state_t;

	// true when pair a must come after pair b
	function automatic logic pair_after(input pair_t a, input pair_t b);
		logic res;
		if (a.distance != b.distance) begin
			res = a.distance > b.distance;
		end else begin
			res = a.label > b.label;
		end
		return res;
	endfunction
endpackage
`default_nettype wire

// ----- sv/pst_in_if.sv -----
// input channel: one (distance, label) pair per beat
`default_nettype none
interface pst_in_if;
	logic                        valid;
	logic                        ready;
	logic [pst_pkg::DIST_W-1:0]  distance;
	logic [pst_pkg::LABEL_W-1:0] class_label;
	logic                        final_pair;

	modport source (output valid, output distance, output class_label, output final_pair,
		input ready);
	modport sink (input valid, input distance, input class_label, input final_pair,
		output ready);
endinterface
`default_nettype wire

// ----- sv/pst_out_if.sv -----
// output channel: one sorted pair per beat
`default_nettype none
interface pst_out_if;
	logic                        valid;
	logic                        ready;
	logic [pst_pkg::DIST_W-1:0]  sorted_distance;
	logic [pst_pkg::LABEL_W-1:0] sorted_label;
	logic [pst_pkg::RANK_W-1:0]  rank;
	logic                        overflowed;
	logic                        last_result;

	modport source (output valid, output sorted_distance, output sorted_label, output rank,
		output overflowed, output last_result, input ready);
	modport sink (input valid, input sorted_distance, input sorted_label, input rank,
		input overflowed, input last_result, output ready);
endinterface
`default_nettype wire

// ----- sv/pair_sorter_with_label_tiebreak.sv -----
// sorter for (distance, label) pairs: ascending distance, label breaks ties
//
// pairs enters on a valid/ready channel, one pair per beat; final_pair marks
// the last pair of a set. up to 64 pairs are kept per set; further pairs are
// dropped and every result of that set then carries overflowed.
// after the final pair the set leaves on results, one pair per beat, in
// ascending order with rank counting from zero and last_result on the final
// beat; the store is then empty for the next set.
// pairs are inserted into a sorted row of cells, one per cycle while
// loading, and leave by shifting that row, one per cycle when not stalled.
// the first result is registered once the final pair is in the row.
// a four-entry queue between the front end and the sorting back end keeps
// taking pairs while the back end drains; once it fills, pairs.ready drops.
// a stall on results holds the output register and pauses the drain.
// reset (arst_n low) empties the queue and the store and drops any result.
`default_nettype none
module pair_sorter_with_label_tiebreak (
	input  wire logic clk,
	input  wire logic arst_n,
	pst_in_if.sink    pairs,
	pst_out_if.source results
);
	logic              push_valid;
	logic              push_ready;
	pst_pkg::q_entry_t push_entry;
	logic              pop_valid;
	logic              pop_ready;
	pst_pkg::q_entry_t pop_entry;

	pst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pairs      (pairs),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	pst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	pst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop_ready (pop_ready),
		.results   (results)
	);
endmodule
`default_nettype wire

// ----- sv/pst_front.sv -----
// front end: accepts pairs, tracks set fill and overflow, tags queue entries
`default_nettype none
module pst_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	pst_in_if.sink                 pairs,
	output logic                   push_valid,
	output pst_pkg::q_entry_t      push_entry,
	input  wire logic              push_ready
);
	logic [pst_pkg::CNT_W-1:0] count_q;
	logic                      ovf_q;
	logic                      keep;
	logic                      accept;

	assign pairs.ready = push_ready;
	assign accept      = pairs.valid & push_ready;
	assign keep        = count_q < pst_pkg::CNT_W'(pst_pkg::MAX_PAIRS);

	always_comb begin
		push_valid               = pairs.valid;
		push_entry.pair.distance = pairs.distance;
		push_entry.pair.label    = pairs.class_label[pst_pkg::KEPT_LABEL_W-1:0];
		push_entry.keep          = keep;
		push_entry.fin           = pairs.final_pair;
		push_entry.ovf           = ovf_q | ~keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (pairs.final_pair) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_q + pst_pkg::CNT_W'(keep);
				ovf_q   <= ovf_q | ~keep;
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/pst_queue.sv -----
// short fifo between front and back end
`default_nettype none
module pst_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	input  pst_pkg::q_entry_t      push_entry,
	output logic                   push_ready,
	output logic                   pop_valid,
	output pst_pkg::q_entry_t      pop_entry,
	input  wire logic              pop_ready
);
	pst_pkg::q_entry_t          slots_q [pst_pkg::QUEUE_DEPTH];
	logic [pst_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [pst_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [pst_pkg::QPTR_W:0]   fill_q;
	logic                       push;
	logic                       pop;

	assign push_ready = fill_q != (pst_pkg::QPTR_W + 1)'(pst_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_entry  = slots_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + pst_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + pst_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (pst_pkg::QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (pst_pkg::QPTR_W + 1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/pst_back.sv -----
// back end: sorted insertion row of cells and drain through an output register
`default_nettype none
`include "pair_sorter_with_label_tiebreak_macros.svh"
module pst_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pop_valid,
	input  pst_pkg::q_entry_t      pop_entry,
	output logic                   pop_ready,
	pst_out_if.source              results
);
	localparam int N = pst_pkg::MAX_PAIRS;

	pst_pkg::pair_t               cell_q [N];
	logic [N-1:0]                 valid_q;
	logic [pst_pkg::CNT_W-1:0]    cnt_q;
	logic [pst_pkg::RANK_W-1:0]   rank_q;
	logic                         ovf_q;
	pst_pkg::back_state_t         state_q;
	pst_pkg::back_state_t         state_d;

	logic                         out_valid_q;
	pst_pkg::pair_t               out_pair_q;
	logic [pst_pkg::RANK_W-1:0]   out_rank_q;
	logic                         out_ovf_q;
	logic                         out_last_q;

	logic                         pop;
	logic                         do_insert;
	logic                         emit;
	logic                         slot_free;
	logic                         last_now;
	logic [pst_pkg::CNT_W-1:0]    cnt_after;
	logic [N-1:0]                 ins;

	assign slot_free = ~out_valid_q | results.ready;
	assign last_now  = cnt_q == pst_pkg::CNT_W'(1);
	assign cnt_after = cnt_q + pst_pkg::CNT_W'(pop_entry.keep);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pst_pkg::BK_LOAD: begin
				if (pop_valid && pop_entry.fin && cnt_after != '0) begin
					state_d = pst_pkg::BK_DRAIN;
				end
			end
			pst_pkg::BK_DRAIN: begin
				if (cnt_q == '0 || (slot_free && last_now)) begin
					state_d = pst_pkg::BK_LOAD;
				end
			end
			default: state_d = pst_pkg::BK_LOAD;
		endcase
	end

	// state outputs
	always_comb begin
		pop_ready = 1'b0;
		emit      = 1'b0;
		case (state_q)
			pst_pkg::BK_LOAD:  pop_ready = 1'b1;
			pst_pkg::BK_DRAIN: emit = slot_free & (cnt_q != '0);
			default: begin
				pop_ready = 1'b0;
				emit      = 1'b0;
			end
		endcase
	end

	assign pop       = pop_valid & pop_ready;
	assign do_insert = pop & pop_entry.keep;

	// empty cells act as larger than any pair
	always_comb begin
		for (int i = 0; i < N; i++) begin
			ins[i] = ~valid_q[i] | pst_pkg::pair_after(cell_q[i], pop_entry.pair);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_insert && ins[i]) begin
				if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
					cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
				end else begin
					cell_q[i] <= pop_entry.pair;
				end
			end else if (emit && i < N - 1) begin
				cell_q[i] <= cell_q[(i < N - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pst_pkg::BK_LOAD;
			valid_q <= '0;
			cnt_q   <= '0;
			rank_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_insert) begin
				valid_q <= valid_q | {valid_q[N-2:0], 1'b1};
				cnt_q   <= cnt_q + pst_pkg::CNT_W'(1);
			end else if (emit) begin
				valid_q <= valid_q >> 1;
				cnt_q   <= cnt_q - pst_pkg::CNT_W'(1);
			end
			if (pop && pop_entry.fin) begin
				ovf_q <= pop_entry.ovf;
			end
			if (emit) begin
				rank_q <= last_now ? '0 : rank_q + pst_pkg::RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pair_q <= cell_q[0];
			out_rank_q <= rank_q;
			out_ovf_q  <= ovf_q;
			out_last_q <= last_now;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.sorted_distance = out_pair_q.distance;
	assign results.sorted_label    = pst_pkg::LABEL_W'(out_pair_q.label);
	assign results.rank            = out_rank_q;
	assign results.overflowed      = out_ovf_q;
	assign results.last_result     = out_last_q;

	`PST_ASSERT_ALWAYS(a_fill_matches_count, $countones(valid_q) == 32'(cnt_q))
	`PST_ASSERT_ALWAYS(a_drain_not_empty, state_q != pst_pkg::BK_DRAIN || cnt_q != '0)
	`PST_ASSERT_ALWAYS(a_head_ordered, !valid_q[1] || !pst_pkg::pair_after(cell_q[0], cell_q[1]))
	`PST_ASSERT_NEXT(a_last_empties, emit && last_now, state_q == pst_pkg::BK_LOAD && cnt_q == '0)
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the pair sorter: directed and random pair sets checked against a sorting predictor
`timescale 1ns / 1ps
module tb_top;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 50;
	localparam int DIR_N          = 20;
	localparam int PHASE1_END     = 240;
	localparam int PHASE2_END     = 280;
	localparam int RANDOM_ITEMS   = 320;

	typedef struct packed {
		logic [pst_pkg::DIST_W-1:0]  distance;
		logic [pst_pkg::LABEL_W-1:0] label;
		logic [pst_pkg::RANK_W-1:0]  rank;
		logic                        ovf;
		logic                        is_last;
	} sorted_beat_t;

	typedef struct packed {
		logic [pst_pkg::DIST_W-1:0]  distance;
		logic [pst_pkg::LABEL_W-1:0] label;
		logic                        fin;
		logic                        typed;
		sorted_beat_t                want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	pst_in_if  pairs_if ();
	pst_out_if results_if ();

	pair_sorter_with_label_tiebreak u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pairs   (pairs_if),
		.results (results_if)
	);

	pst_pkg::pair_t held_pairs [$];
	logic           held_overflow;
	sorted_beat_t   sorted_expected [$];
	int             failures;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             stall_cycles;
	dir_row_t       directed_rows [DIR_N];

	always #5 clk = ~clk;

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	// store the pair; on the last pair of a set, sort and queue the whole drain
	function automatic void sort_pair_set(input logic [pst_pkg::DIST_W-1:0] d,
		input logic [pst_pkg::LABEL_W-1:0] l, input logic fin);
		pst_pkg::pair_t incoming;
		pst_pkg::pair_t moving;
		pst_pkg::pair_t ranked [$];
		sorted_beat_t   beat;
		int             j;
		incoming.distance = d;
		incoming.label    = l[pst_pkg::KEPT_LABEL_W-1:0];
		if (held_pairs.size() < pst_pkg::MAX_PAIRS) begin
			held_pairs.push_back(incoming);
		end else begin
			held_overflow = 1'b1;
		end
		if (!fin) begin
			return;
		end
		ranked = held_pairs;
		// packed pair compares as {distance, label}, which is the sort order
		for (int i = 1; i < ranked.size(); i++) begin
			moving = ranked[i];
			j = i;
			while (j > 0 && ranked[j-1] > moving) begin
				ranked[j] = ranked[j-1];
				j--;
			end
			ranked[j] = moving;
		end
		for (int i = 0; i < ranked.size(); i++) begin
			beat = '0;
			beat.distance = ranked[i].distance;
			beat.label[pst_pkg::KEPT_LABEL_W-1:0] = ranked[i].label;
			beat.rank = i[pst_pkg::RANK_W-1:0];
			beat.ovf = held_overflow;
			beat.is_last = (i == ranked.size() - 1);
			sorted_expected.push_back(beat);
		end
		held_pairs.delete();
		held_overflow = 1'b0;
	endfunction

	function automatic logic [pst_pkg::DIST_W-1:0] pick_distance();
		int r;
		r = $urandom_range(9);
		if (r < 3) begin
			return pst_pkg::DIST_W'($urandom_range(7));
		end else if (r == 3) begin
			return $urandom_range(1) ? '1 : '0;
		end
		return $urandom;
	endfunction

	function automatic logic [pst_pkg::LABEL_W-1:0] pick_label();
		if ($urandom_range(1)) begin
			return pst_pkg::LABEL_W'($urandom_range(3));
		end
		return pst_pkg::LABEL_W'($urandom_range(255));
	endfunction

	task automatic send_pair(input logic [pst_pkg::DIST_W-1:0] d,
		input logic [pst_pkg::LABEL_W-1:0] l, input logic fin, input logic typed,
		input sorted_beat_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			pairs_if.valid <= 1'b0;
			@(posedge clk);
		end
		pairs_if.valid       <= 1'b1;
		pairs_if.distance    <= d;
		pairs_if.class_label <= l;
		pairs_if.final_pair  <= fin;
		@(posedge clk);
		while (!pairs_if.ready) begin
			@(posedge clk);
		end
		sort_pair_set(d, l, fin);
		if (typed) begin
			void'(sorted_expected.pop_back());
			sorted_expected.push_back(want);
		end
	endtask

	task automatic send_random_set(input int set_size);
		for (int i = 0; i < set_size; i++) begin
			send_pair(pick_distance(), pick_label(), i == set_size - 1, 1'b0, '0);
		end
	endtask

	task automatic wait_for_drain();
		pairs_if.valid <= 1'b0;
		@(posedge clk);
		while (sorted_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic run_random_until(input int item_goal, inout int items_sent);
		int r;
		int set_size;
		while (items_sent < item_goal) begin
			r = $urandom_range(99);
			if (r < 85) begin
				set_size = $urandom_range(8, 1);
			end else if (r < 95) begin
				set_size = $urandom_range(24, 9);
			end else begin
				set_size = $urandom_range(pst_pkg::MAX_PAIRS + 4, pst_pkg::MAX_PAIRS - 4);
			end
			send_random_set(set_size);
			items_sent += set_size;
		end
	endtask

	always @(posedge clk) begin
		results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pairs_if.valid && pairs_if.ready) || (results_if.valid && results_if.ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		sorted_beat_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (sorted_expected.size() == 0) begin
				note_failure($sformatf("unexpected result: dist %h label %h rank %0d ovf %b last %b",
					results_if.sorted_distance, results_if.sorted_label, results_if.rank,
					results_if.overflowed, results_if.last_result));
			end else begin
				want = sorted_expected.pop_front();
				if (results_if.sorted_distance !== want.distance ||
					results_if.sorted_label !== want.label ||
					results_if.rank !== want.rank || results_if.overflowed !== want.ovf ||
					results_if.last_result !== want.is_last) begin
					note_failure($sformatf({"mismatch: exp dist %h label %h rank %0d ovf %b last %b, ",
						"got dist %h label %h rank %0d ovf %b last %b"},
						want.distance, want.label, want.rank, want.ovf, want.is_last,
						results_if.sorted_distance, results_if.sorted_label, results_if.rank,
						results_if.overflowed, results_if.last_result));
				end
			end
		end
	end

	initial begin
		int items_sent;
		clk = 1'b0;
		arst_n = 1'b0;
		pairs_if.valid = 1'b0;
		pairs_if.distance = '0;
		pairs_if.class_label = '0;
		pairs_if.final_pair = 1'b0;
		results_if.ready = 1'b0;
		held_overflow = 1'b0;
		failures = 0;
		stall_cycles = 0;
		items_sent = 0;
		send_idle_pct = 35;
		recv_idle_pct = 70;

		// single-pair sets have an obvious answer; the rest go through the predictor
		directed_rows = '{
			'{32'h0000_0000, 8'h00, 1'b1, 1'b1, '{32'h0000_0000, 8'h00, 6'd0, 1'b0, 1'b1}},
			'{32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 8'hFF, 6'd0, 1'b0, 1'b1}},
			'{32'h0001_0000, 8'h80, 1'b1, 1'b1, '{32'h0001_0000, 8'h80, 6'd0, 1'b0, 1'b1}},
			'{32'h0000_0005, 8'h03, 1'b0, 1'b0, '0},
			'{32'h0000_0005, 8'h01, 1'b0, 1'b0, '0},
			'{32'h0000_0005, 8'h02, 1'b0, 1'b0, '0},
			'{32'h0000_0002, 8'hFF, 1'b0, 1'b0, '0},
			'{32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
			'{32'h0000_0000, 8'hFF, 1'b1, 1'b0, '0},
			'{32'h0000_0007, 8'h07, 1'b0, 1'b0, '0},
			'{32'h0000_0007, 8'h07, 1'b1, 1'b0, '0},
			'{32'h0000_001E, 8'h09, 1'b0, 1'b0, '0},
			'{32'h0000_0014, 8'h09, 1'b0, 1'b0, '0},
			'{32'h0000_000A, 8'h09, 1'b1, 1'b0, '0},
			'{32'hAAAA_AAAA, 8'h55, 1'b0, 1'b0, '0},
			'{32'h5555_5555, 8'hAA, 1'b0, 1'b0, '0},
			'{32'hAAAA_AAAA, 8'h54, 1'b1, 1'b0, '0},
			'{32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, '0},
			'{32'hFFFF_FFFF, 8'hFE, 1'b0, 1'b0, '0},
			'{32'hFFFF_FFFE, 8'hFF, 1'b1, 1'b0, '0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			send_pair(directed_rows[i].distance, directed_rows[i].label, directed_rows[i].fin,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// exactly full, then one and four pairs past capacity (pairs past the 64th dropped)
		send_random_set(pst_pkg::MAX_PAIRS);
		send_random_set(pst_pkg::MAX_PAIRS + 1);
		send_random_set(pst_pkg::MAX_PAIRS + 4);
		items_sent = DIR_N + 3 * pst_pkg::MAX_PAIRS + 5;

		run_random_until(PHASE1_END, items_sent);
		wait_for_drain();
		send_idle_pct = 70;
		recv_idle_pct = 35;
		run_random_until(PHASE2_END, items_sent);
		wait_for_drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_until(RANDOM_ITEMS, items_sent);

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
